[src/ssp_pkg.sv]
// Shared types and fixed widths for the sprite screen projection pipeline.
// No dependencies; every other file of the block but ssp_div refers to it by scoped names.
`default_nettype none

package ssp_pkg;

  // Fixed operand widths of the camera-space transform
  localparam int DET_W  = 33;  // signed determinant, Q4.28
  localparam int DEN_W  = 32;  // magnitude of any divisor
  localparam int Q_SHIFT = 22; // scale of nx, ny to Q16.16 after division
  localparam int NUM1_W = 54;  // magnitude of nx * 2^22

  // One input item
  typedef struct packed {
    logic [15:0]        sprite_pos_x;
    logic [15:0]        sprite_pos_y;
    logic [15:0]        viewer_pos_x;
    logic [15:0]        viewer_pos_y;
    logic signed [15:0] view_dir_x;
    logic signed [15:0] view_dir_y;
    logic signed [15:0] plane_x;
    logic signed [15:0] plane_y;
  } in_t;

  // One result item
  typedef struct packed {
    logic signed [31:0] camera_x;
    logic signed [31:0] depth;
    logic signed [15:0] center_column;
    logic [15:0]        sprite_size;
    logic [8:0]         top_row;
    logic [9:0]         bottom_row;
    logic [14:0]        left_column;
    logic signed [15:0] right_column;
    logic               invalid;
  } out_t;

  // Signs and flags riding along the transform divider
  typedef struct packed {
    logic neg_x;
    logic neg_y;
    logic det_zero;
  } sign1_t;

  // Operands of the transform divider
  typedef struct packed {
    logic [NUM1_W-1:0] num_x;
    logic [NUM1_W-1:0] num_y;
    logic [DEN_W-1:0]  den;
    sign1_t            tag;
  } front_t;

  // Camera-space values riding along the screen divider
  typedef struct packed {
    logic signed [31:0] tx;
    logic signed [31:0] ty;
    logic               bad;
    logic               neg_c;
  } mid_t;

endpackage

`default_nettype wire

[src/ssp_div.sv]
// Pipelined restoring divider: two numerators over one shared divisor,
// one quotient bit per stage, with a tag carried alongside. Uses nothing else.
`default_nettype none

module ssp_div #(
  parameter int NW = 54,
  parameter int DW = 32,
  parameter int PW = 3
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          op_valid,
  input  wire logic [NW-1:0] op_num_a,
  input  wire logic [NW-1:0] op_num_b,
  input  wire logic [DW-1:0] op_den,
  input  wire logic [PW-1:0] op_tag,
  output logic               res_valid,
  output logic [NW-1:0]      res_quo_a,
  output logic [NW-1:0]      res_quo_b,
  output logic [PW-1:0]      res_tag
);

  // Stage registers; numerator bits shift out as quotient bits shift in
  logic          st_v     [NW];
  logic [DW-1:0] st_rem_a [NW];
  logic [DW-1:0] st_rem_b [NW];
  logic [NW-1:0] st_nq_a  [NW];
  logic [NW-1:0] st_nq_b  [NW];
  logic [DW-1:0] st_den   [NW];
  logic [PW-1:0] st_tag   [NW];

  for (genvar k = 0; k < NW; k++) begin : g_step
    logic          v_src;
    logic [DW-1:0] rem_a_src;
    logic [DW-1:0] rem_b_src;
    logic [NW-1:0] nq_a_src;
    logic [NW-1:0] nq_b_src;
    logic [DW-1:0] den_src;
    logic [PW-1:0] tag_src;
    logic [DW:0]   t_a;
    logic [DW:0]   t_b;
    logic [DW:0]   d_a;
    logic [DW:0]   d_b;
    logic          ge_a;
    logic          ge_b;

    if (k == 0) begin : g_head
      assign v_src     = op_valid;
      assign rem_a_src = '0;
      assign rem_b_src = '0;
      assign nq_a_src  = op_num_a;
      assign nq_b_src  = op_num_b;
      assign den_src   = op_den;
      assign tag_src   = op_tag;
    end else begin : g_link
      assign v_src     = st_v[k-1];
      assign rem_a_src = st_rem_a[k-1];
      assign rem_b_src = st_rem_b[k-1];
      assign nq_a_src  = st_nq_a[k-1];
      assign nq_b_src  = st_nq_b[k-1];
      assign den_src   = st_den[k-1];
      assign tag_src   = st_tag[k-1];
    end

    // Trial subtract for both lanes
    assign t_a  = {rem_a_src, nq_a_src[NW-1]};
    assign t_b  = {rem_b_src, nq_b_src[NW-1]};
    assign d_a  = t_a - {1'b0, den_src};
    assign d_b  = t_b - {1'b0, den_src};
    assign ge_a = (t_a >= {1'b0, den_src});
    assign ge_b = (t_b >= {1'b0, den_src});

    always_ff @(posedge clk) begin
      if (rst) begin
        st_v[k] <= 1'b0;
      end else if (en) begin
        st_v[k] <= v_src;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_rem_a[k] <= ge_a ? d_a[DW-1:0] : t_a[DW-1:0];
        st_rem_b[k] <= ge_b ? d_b[DW-1:0] : t_b[DW-1:0];
        st_nq_a[k]  <= {nq_a_src[NW-2:0], ge_a};
        st_nq_b[k]  <= {nq_b_src[NW-2:0], ge_b};
        st_den[k]   <= den_src;
        st_tag[k]   <= tag_src;
      end
    end
  end

  assign res_valid = st_v[NW-1];
  assign res_quo_a = st_nq_a[NW-1];
  assign res_quo_b = st_nq_b[NW-1];
  assign res_tag   = st_tag[NW-1];

endmodule

`default_nettype wire

[src/ssp_front.sv]
// Front end: offsets, products, determinant and numerators, then magnitudes
// and signs for the transform divider. Depends on ssp_pkg.
`default_nettype none

module ssp_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          item_valid,
  input  wire ssp_pkg::in_t  item,
  output logic               op_valid,
  output ssp_pkg::front_t    op
);

  // Stage A: offsets from the viewer
  logic               a_v;
  logic signed [16:0] a_dx, a_dy;
  logic signed [15:0] a_vx, a_vy, a_px, a_py;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else if (en) begin
      a_v <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_dx <= $signed({1'b0, item.sprite_pos_x}) - $signed({1'b0, item.viewer_pos_x});
      a_dy <= $signed({1'b0, item.sprite_pos_y}) - $signed({1'b0, item.viewer_pos_y});
      a_vx <= item.view_dir_x;
      a_vy <= item.view_dir_y;
      a_px <= item.plane_x;
      a_py <= item.plane_y;
    end
  end

  // Stage B: the six products
  logic               b_v;
  logic signed [31:0] b_pxvy, b_vxpy;
  logic signed [32:0] b_vydx, b_vxdy, b_pxdy, b_pydx;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_v <= 1'b0;
    end else if (en) begin
      b_v <= a_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_pxvy <= 32'(a_px * a_vy);
      b_vxpy <= 32'(a_vx * a_py);
      b_vydx <= 33'(a_vy * a_dx);
      b_vxdy <= 33'(a_vx * a_dy);
      b_pxdy <= 33'(a_px * a_dy);
      b_pydx <= 33'(a_py * a_dx);
    end
  end

  // Stage C: determinant and numerators
  logic                                c_v;
  logic signed [ssp_pkg::DET_W-1:0]    c_det;
  logic signed [33:0]                  c_nx, c_ny;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_v <= 1'b0;
    end else if (en) begin
      c_v <= b_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_det <= ssp_pkg::DET_W'(b_pxvy) - ssp_pkg::DET_W'(b_vxpy);
      c_nx  <= 34'(b_vydx) - 34'(b_vxdy);
      c_ny  <= 34'(b_pxdy) - 34'(b_pydx);
    end
  end

  // Stage D: magnitudes and quotient signs
  logic signed [ssp_pkg::DET_W-1:0] det_neg;
  logic signed [33:0]               nx_neg, ny_neg;
  logic [ssp_pkg::DEN_W-1:0]        det_mag;
  logic [31:0]                      nx_mag, ny_mag;

  always_comb begin
    det_neg = -c_det;
    nx_neg  = -c_nx;
    ny_neg  = -c_ny;
    det_mag = c_det[ssp_pkg::DET_W-1] ? det_neg[ssp_pkg::DEN_W-1:0] : c_det[ssp_pkg::DEN_W-1:0];
    nx_mag  = c_nx[33] ? nx_neg[31:0] : c_nx[31:0];
    ny_mag  = c_ny[33] ? ny_neg[31:0] : c_ny[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      op_valid <= 1'b0;
    end else if (en) begin
      op_valid <= c_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op.num_x        <= {nx_mag, {ssp_pkg::Q_SHIFT{1'b0}}};
      op.num_y        <= {ny_mag, {ssp_pkg::Q_SHIFT{1'b0}}};
      op.den          <= det_mag;
      op.tag.neg_x    <= c_nx[33] ^ c_det[ssp_pkg::DET_W-1];
      op.tag.neg_y    <= c_ny[33] ^ c_det[ssp_pkg::DET_W-1];
      op.tag.det_zero <= (c_det == '0);
    end
  end

endmodule

`default_nettype wire

[src/ssp_mid.sv]
// Middle section: saturates camera-space values to Q16.16 and builds the
// operands for the screen divider (center and size). Depends on ssp_pkg.
`default_nettype none

module ssp_mid #(
  parameter int SCREEN_WIDTH  = 1024,
  parameter int SCREEN_HEIGHT = 768,
  parameter int NW2           = 43
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          en,
  input  wire logic                          quo_valid,
  input  wire logic [ssp_pkg::NUM1_W-1:0]    quo_x,
  input  wire logic [ssp_pkg::NUM1_W-1:0]    quo_y,
  input  wire ssp_pkg::sign1_t               quo_tag,
  output logic                               op_valid,
  output logic [NW2-1:0]                     num_c,
  output logic [NW2-1:0]                     num_s,
  output logic [ssp_pkg::DEN_W-1:0]          den,
  output ssp_pkg::mid_t                      tag
);

  localparam int HW_W = $clog2(SCREEN_WIDTH / 2 + 1);
  localparam logic [HW_W-1:0] HALF_WIDTH = HW_W'(SCREEN_WIDTH / 2);
  localparam logic [NW2-1:0]  SIZE_NUM   = NW2'(SCREEN_HEIGHT * 65536);
  localparam logic [ssp_pkg::NUM1_W-1:0] SAT_NEG =
    {{(ssp_pkg::NUM1_W-32){1'b0}}, 32'h8000_0000};
  localparam logic [ssp_pkg::NUM1_W-1:0] SAT_POS =
    {{(ssp_pkg::NUM1_W-32){1'b0}}, 32'h7fff_ffff};

  // Truncated quotient magnitude and sign to saturated Q16.16
  function automatic logic signed [31:0] sat_q16(input logic [ssp_pkg::NUM1_W-1:0] mag,
                                                input logic neg);
    logic signed [31:0] res;
    if (neg) begin
      res = (mag > SAT_NEG) ? 32'sh8000_0000 : -$signed(mag[31:0]);
    end else begin
      res = (mag > SAT_POS) ? 32'sh7fff_ffff : $signed(mag[31:0]);
    end
    return res;
  endfunction

  // Stage M1: saturate
  logic               m1_v;
  logic signed [31:0] m1_tx, m1_ty;
  logic               m1_det0;

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_v <= 1'b0;
    end else if (en) begin
      m1_v <= quo_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_tx   <= quo_tag.det_zero ? '0 : sat_q16(quo_x, quo_tag.neg_x);
      m1_ty   <= quo_tag.det_zero ? '0 : sat_q16(quo_y, quo_tag.neg_y);
      m1_det0 <= quo_tag.det_zero;
    end
  end

  // Stage M2: invalid flag, sum magnitude, depth magnitude
  logic signed [32:0] sum, sum_neg;
  logic signed [31:0] ty_neg;

  always_comb begin
    sum     = 33'(m1_tx) + 33'(m1_ty);
    sum_neg = -sum;
    ty_neg  = -m1_ty;
  end

  logic               m2_v;
  logic signed [31:0] m2_tx, m2_ty;
  logic               m2_bad, m2_neg_c;
  logic [32:0]        m2_sum_mag;
  logic [31:0]        m2_ty_mag;

  always_ff @(posedge clk) begin
    if (rst) begin
      m2_v <= 1'b0;
    end else if (en) begin
      m2_v <= m1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m2_tx      <= m1_tx;
      m2_ty      <= m1_ty;
      m2_bad     <= m1_det0 | (m1_ty == '0);
      m2_neg_c   <= sum[32] ^ m1_ty[31];
      m2_sum_mag <= sum[32] ? sum_neg : sum;
      m2_ty_mag  <= m1_ty[31] ? ty_neg : m1_ty;
    end
  end

  // Stage M3: scale the center numerator by half the screen width
  always_ff @(posedge clk) begin
    if (rst) begin
      op_valid <= 1'b0;
    end else if (en) begin
      op_valid <= m2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_c     <= NW2'(m2_sum_mag * HALF_WIDTH);
      den       <= m2_ty_mag;
      tag.tx    <= m2_tx;
      tag.ty    <= m2_ty;
      tag.bad   <= m2_bad;
      tag.neg_c <= m2_neg_c;
    end
  end

  assign num_s = SIZE_NUM;

endmodule

`default_nettype wire

[src/ssp_back.sv]
// Back end: saturates center column and size, then clamps the drawing
// rectangle to the screen. Depends on ssp_pkg.
`default_nettype none

module ssp_back #(
  parameter int SCREEN_WIDTH  = 1024,
  parameter int SCREEN_HEIGHT = 768,
  parameter int NW2           = 43
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           en,
  input  wire logic           quo_valid,
  input  wire logic [NW2-1:0] quo_c,
  input  wire logic [NW2-1:0] quo_s,
  input  wire ssp_pkg::mid_t  quo_tag,
  output logic                res_valid,
  output ssp_pkg::out_t       res
);

  localparam logic signed [17:0] HALF_H = 18'(SCREEN_HEIGHT / 2);
  localparam logic signed [17:0] SCR_H  = 18'(SCREEN_HEIGHT);
  localparam logic signed [17:0] SCR_W  = 18'(SCREEN_WIDTH);

  // Stage B1: saturate center and size
  logic signed [15:0] center_c;
  logic [15:0]        size_c;

  always_comb begin
    if (quo_tag.neg_c) begin
      center_c = (quo_c > NW2'(32768)) ? 16'sh8000 : -$signed(quo_c[15:0]);
    end else begin
      center_c = (quo_c > NW2'(32767)) ? 16'sh7fff : $signed(quo_c[15:0]);
    end
    size_c = (quo_s > NW2'(65535)) ? 16'hffff : quo_s[15:0];
  end

  logic               b1_v;
  logic signed [15:0] b1_center;
  logic [15:0]        b1_size;
  ssp_pkg::mid_t      b1_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_v <= 1'b0;
    end else if (en) begin
      b1_v <= quo_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b1_center <= quo_tag.bad ? '0 : center_c;
      b1_size   <= quo_tag.bad ? '0 : size_c;
      b1_tag    <= quo_tag;
    end
  end

  // Stage B2: rectangle and clamps
  logic signed [17:0] half, cen, top_s, bot_s, left_s, right_s;
  logic signed [17:0] top_k, bot_k, left_k, right_k;

  always_comb begin
    half    = $signed({3'b000, b1_size[15:1]});
    cen     = 18'(b1_center);
    top_s   = HALF_H - half;
    bot_s   = HALF_H + half;
    left_s  = cen - half;
    right_s = cen + half;
    top_k   = top_s[17] ? '0 : top_s;
    bot_k   = (bot_s >= SCR_H) ? SCR_H - 18'sd1 : bot_s;
    if (left_s[17]) begin
      left_k = '0;
    end else if (left_s > 18'sd32767) begin
      left_k = 18'sd32767;
    end else begin
      left_k = left_s;
    end
    right_k = (right_s >= SCR_W) ? SCR_W - 18'sd1 : right_s;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (en) begin
      res_valid <= b1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res.camera_x      <= b1_tag.tx;
      res.depth         <= b1_tag.ty;
      res.center_column <= b1_center;
      res.sprite_size   <= b1_size;
      res.top_row       <= b1_tag.bad ? '0 : 9'(top_k);
      res.bottom_row    <= b1_tag.bad ? '0 : 10'(bot_k);
      res.left_column   <= b1_tag.bad ? '0 : 15'(left_k);
      res.right_column  <= b1_tag.bad ? '0 : 16'(right_k);
      res.invalid       <= b1_tag.bad;
    end
  end

endmodule

`default_nettype wire

[src/sprite_screen_projection_unit.sv]
// Path from input transfer to proj_valid: front end, the two bit-per-stage
// divider pipelines (54 stages for the camera transform, NUM2_W stages for
// column and size), middle and back sections, then the output register.
// Throughput: one item per cycle while the skid register is empty; the output
// register plus a skid register absorb the result that arrives as the consumer stalls.
// Reset (rst, synchronous): clears all valid bits, including those of the output and skid stages.
`default_nettype none

module sprite_screen_projection_unit #(
  parameter int SCREEN_WIDTH  = 1024,
  parameter int SCREEN_HEIGHT = 768
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          sprite_valid,
  output logic               sprite_ready,
  input  wire ssp_pkg::in_t  sprite_item,
  output logic               proj_valid,
  input  wire logic          proj_ready,
  output ssp_pkg::out_t      proj_item
);

  localparam int CN_W   = 33 + $clog2(SCREEN_WIDTH / 2 + 1);
  localparam int SN_W   = $clog2(SCREEN_HEIGHT + 1) + 16;
  localparam int NUM2_W = (CN_W > SN_W) ? CN_W : SN_W;

  logic skid_v;
  ssp_pkg::out_t skid_d;
  logic en;

  // Whole pipeline advances unless the skid register is occupied
  assign en           = !skid_v;
  assign sprite_ready = en;

  // Front end
  logic             front_v;
  ssp_pkg::front_t  front_op;

  ssp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .item_valid (sprite_valid),
    .item       (sprite_item),
    .op_valid   (front_v),
    .op         (front_op)
  );

  // Camera transform divider
  logic                           d1_v;
  logic [ssp_pkg::NUM1_W-1:0]     d1_qx, d1_qy;
  ssp_pkg::sign1_t                d1_tag;

  ssp_div #(
    .NW (ssp_pkg::NUM1_W),
    .DW (ssp_pkg::DEN_W),
    .PW ($bits(ssp_pkg::sign1_t))
  ) u_div_cam (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .op_valid  (front_v),
    .op_num_a  (front_op.num_x),
    .op_num_b  (front_op.num_y),
    .op_den    (front_op.den),
    .op_tag    (front_op.tag),
    .res_valid (d1_v),
    .res_quo_a (d1_qx),
    .res_quo_b (d1_qy),
    .res_tag   (d1_tag)
  );

  // Saturation and screen operands
  logic                       mid_v;
  logic [NUM2_W-1:0]          mid_num_c, mid_num_s;
  logic [ssp_pkg::DEN_W-1:0]  mid_den;
  ssp_pkg::mid_t              mid_tag;

  ssp_mid #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .NW2           (NUM2_W)
  ) u_mid (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .quo_valid (d1_v),
    .quo_x     (d1_qx),
    .quo_y     (d1_qy),
    .quo_tag   (d1_tag),
    .op_valid  (mid_v),
    .num_c     (mid_num_c),
    .num_s     (mid_num_s),
    .den       (mid_den),
    .tag       (mid_tag)
  );

  // Screen divider: center column and size share the depth divisor
  logic               d2_v;
  logic [NUM2_W-1:0]  d2_qc, d2_qs;
  ssp_pkg::mid_t      d2_tag;

  ssp_div #(
    .NW (NUM2_W),
    .DW (ssp_pkg::DEN_W),
    .PW ($bits(ssp_pkg::mid_t))
  ) u_div_scr (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .op_valid  (mid_v),
    .op_num_a  (mid_num_c),
    .op_num_b  (mid_num_s),
    .op_den    (mid_den),
    .op_tag    (mid_tag),
    .res_valid (d2_v),
    .res_quo_a (d2_qc),
    .res_quo_b (d2_qs),
    .res_tag   (d2_tag)
  );

  // Rectangle
  logic          back_v;
  ssp_pkg::out_t back_res;

  ssp_back #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .NW2           (NUM2_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .quo_valid (d2_v),
    .quo_c     (d2_qc),
    .quo_s     (d2_qs),
    .quo_tag   (d2_tag),
    .res_valid (back_v),
    .res       (back_res)
  );

  // Output register with skid stage
  logic push, pop;

  assign push = back_v & en;
  assign pop  = proj_valid & proj_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      proj_valid <= 1'b0;
      skid_v     <= 1'b0;
    end else if (skid_v) begin
      if (pop) begin
        skid_v <= 1'b0;
      end
    end else if (!proj_valid || pop) begin
      proj_valid <= push;
    end else if (push) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v) begin
      if (pop) begin
        proj_item <= skid_d;
      end
    end else if (!proj_valid || pop) begin
      proj_item <= back_res;
    end else if (push) begin
      skid_d <= back_res;
    end
  end

`ifndef SYNTHESIS
  // A held skid entry always has a result in front of it
  assert property (@(posedge clk) disable iff (rst) skid_v |-> proj_valid)
    else $error("skid stage occupied while output register empty");

  // Invalid results carry zero size, top row and center column
  assert property (@(posedge clk) disable iff (rst)
    (proj_valid && proj_item.invalid) |->
      (proj_item.sprite_size == '0 && proj_item.top_row == '0 &&
       proj_item.center_column == '0))
    else $error("invalid result with nonzero geometry");

  // Valid results stay inside the screen height
  assert property (@(posedge clk) disable iff (rst)
    (proj_valid && !proj_item.invalid) |->
      (32'(proj_item.bottom_row) < 32'(SCREEN_HEIGHT)))
    else $error("bottom row beyond screen");
`endif

endmodule

`default_nettype wire
